// ===== hw/rtl/drsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drsl_pkg
// Shared types and codes of the depth sorted render list.
// ----------------------------------------------------------------------------
package drsl_pkg;

    localparam int KEY_W = 67;

    // Commands
    localparam logic [2:0] CMD_ADD_PERSIST = 3'd0;
    localparam logic [2:0] CMD_ADD_FRAME   = 3'd1;
    localparam logic [2:0] CMD_REMOVE      = 3'd2;
    localparam logic [2:0] CMD_CLR_PERSIST = 3'd3;
    localparam logic [2:0] CMD_CLR_FRAME   = 3'd4;
    localparam logic [2:0] CMD_SORT        = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CAMERA_X  = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y  = 3'd1;
    localparam logic [2:0] REG_CAMERA_Z  = 3'd2;
    localparam logic [2:0] REG_FORWARD_X = 3'd3;
    localparam logic [2:0] REG_FORWARD_Y = 3'd4;
    localparam logic [2:0] REG_FORWARD_Z = 3'd5;

    localparam logic [31:0] FORWARD_Z_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [15:0]        handle;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               one_frame;
    } entry_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    one_frame;
        logic [15:0]             handle;
    } key_rec_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] fwd_x;
        logic signed [31:0] fwd_y;
        logic signed [31:0] fwd_z;
    } view_t;

endpackage
`default_nettype wire

// ===== hw/rtl/drsl_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drsl_store
// Entry memory and sort key memory, one write and one registered read each.
// ----------------------------------------------------------------------------
module drsl_store
    import drsl_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 6
) (
    input  wire logic             clk,
    input  wire logic             ent_we,
    input  wire logic [IDX_W-1:0] ent_waddr,
    input  wire entry_t           ent_wdata,
    input  wire logic             ent_re,
    input  wire logic [IDX_W-1:0] ent_raddr,
    output entry_t                ent_rdata,
    input  wire logic             key_we,
    input  wire logic [IDX_W-1:0] key_waddr,
    input  wire key_rec_t         key_wdata,
    input  wire logic             key_re,
    input  wire logic [IDX_W-1:0] key_raddr,
    output key_rec_t              key_rdata
);

    entry_t   ent_mem [CAPACITY];
    key_rec_t key_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rdata <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (key_re)
        begin
            key_rdata <= key_mem[key_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/drsl_key_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drsl_key_unit
// Depth key of one entry with a single shared multiplier.
// ----------------------------------------------------------------------------
module drsl_key_unit
    import drsl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire entry_t             entry,
    input  wire view_t              view,
    output logic                    done,
    output logic signed [KEY_W-1:0] key
);

    localparam logic [2:0] STEP_LAST = 3'd6;
    localparam logic [2:0] STEP_CAM  = 3'd4;

    logic               busy_reg;
    logic [2:0]         step_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] pz_reg;
    logic signed [63:0] prod_reg;
    logic signed [KEY_W-1:0] acc_reg;
    logic               done_reg;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [KEY_W-1:0] prod_ext;

    always_comb
    begin
        case (step_reg)
            3'd0:    begin op_a = px_reg;     op_b = view.fwd_x; end
            3'd1:    begin op_a = py_reg;     op_b = view.fwd_y; end
            3'd2:    begin op_a = pz_reg;     op_b = view.fwd_z; end
            3'd3:    begin op_a = view.cam_x; op_b = view.cam_x; end
            3'd4:    begin op_a = view.cam_y; op_b = view.cam_y; end
            default: begin op_a = view.cam_z; op_b = view.cam_z; end
        endcase
        prod_ext = {{(KEY_W-64){prod_reg[63]}}, prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg <= entry.pos_x;
            py_reg <= entry.pos_y;
            pz_reg <= entry.pos_z;
        end
        else if (busy_reg)
        begin
            prod_reg <= op_a * op_b;
            if (step_reg == 3'd0)
            begin
                acc_reg <= '0;
            end
            else if (step_reg >= STEP_CAM)
            begin
                acc_reg <= acc_reg - prod_ext;
            end
            else
            begin
                acc_reg <= acc_reg + prod_ext;
            end
        end
    end

    assign done = done_reg;
    assign key  = acc_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/depth_sorted_render_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_sorted_render_list
// Render entry table with back to front depth sort.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on in_valid/in_ready with a command, a handle and a
//   position. Results leave on out_valid/out_ready, one register deep.
//   Add returns one status in the cycle after acceptance (full when the table
//   holds CAPACITY entries). Remove and the two clears compact the table in
//   place. Sort computes one key per entry with one shared multiplier, then
//   makes one pass over the key memory per result; the key memory read port
//   sets the pass length. Sort of an empty table returns status empty.
//   Commands 6 and 7 are dropped. One request is worked at a time; in_ready is
//   high only when the block is idle and the output register is empty, so a
//   stalled receiver holds the block. Results are ordered by descending key,
//   persistent before one-frame, then insertion order.
//   Reset empties the table and loads the view registers; memories need no
//   clearing. Write configuration via cfg_write only while idle.
// ----------------------------------------------------------------------------
module depth_sorted_render_list
    import drsl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [15:0] handle,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_handle,
    output logic             is_entry,
    output logic [1:0]       status,
    output logic             last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_COMPACT = 3'd1;
    localparam logic [2:0] S_KREAD   = 3'd2;
    localparam logic [2:0] S_KSTART  = 3'd3;
    localparam logic [2:0] S_KWAIT   = 3'd4;
    localparam logic [2:0] S_SCAN    = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    // View registers
    view_t view_reg;

    // Control
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic             rvalid_reg, rvalid_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [15:0]      hnd_reg, hnd_next;
    logic             prev_valid_reg, prev_valid_next;
    logic             best_valid_reg, best_valid_next;

    // Sort payload
    key_rec_t         best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    key_rec_t         prev_reg, prev_next;
    logic [IDX_W-1:0] prev_idx_reg, prev_idx_next;
    logic             kof_reg, kof_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_handle_reg, out_handle_next;
    logic             out_entry_reg, out_entry_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;

    // Store ports
    logic             ent_we, ent_re, key_we, key_re;
    logic [IDX_W-1:0] ent_waddr, ent_raddr, key_waddr, key_raddr;
    entry_t           ent_wdata, ent_rdata;
    key_rec_t         key_wdata, key_rdata;

    logic                    ku_start, ku_done;
    logic signed [KEY_W-1:0] ku_key;

    logic in_fire, out_fire, drop, eligible, better;

    drsl_store #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk       (clk),
        .ent_we    (ent_we),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .ent_re    (ent_re),
        .ent_raddr (ent_raddr),
        .ent_rdata (ent_rdata),
        .key_we    (key_we),
        .key_waddr (key_waddr),
        .key_wdata (key_wdata),
        .key_re    (key_re),
        .key_raddr (key_raddr),
        .key_rdata (key_rdata)
    );

    drsl_key_unit u_key (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ku_start),
        .entry (ent_rdata),
        .view  (view_reg),
        .done  (ku_done),
        .key   (ku_key)
    );

    // Strict order: a goes before b
    function automatic logic goes_before(key_rec_t a, logic [IDX_W-1:0] ai,
                                         key_rec_t b, logic [IDX_W-1:0] bi);
        logic r;
        if (a.key != b.key)
        begin
            r = a.key > b.key;
        end
        else if (a.one_frame != b.one_frame)
        begin
            r = !a.one_frame;
        end
        else
        begin
            r = ai < bi;
        end
        return r;
    endfunction

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    // Compaction: decide whether the entry just read is dropped
    always_comb
    begin
        case (cmd_reg)
            CMD_REMOVE:      drop = !ent_rdata.one_frame && (ent_rdata.handle == hnd_reg);
            CMD_CLR_PERSIST: drop = !ent_rdata.one_frame;
            CMD_CLR_FRAME:   drop = ent_rdata.one_frame;
            default:         drop = 1'b0;
        endcase
    end

    // Scan: candidate must come after the last result and beat the best so far
    assign eligible = !prev_valid_reg ||
                      goes_before(prev_reg, prev_idx_reg, key_rdata, ridx_reg);
    assign better   = !best_valid_reg ||
                      goes_before(key_rdata, ridx_reg, best_reg, best_idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        emitted_next    = emitted_reg;
        rvalid_next     = 1'b0;
        ridx_next       = ridx_reg;
        cmd_next        = cmd_reg;
        hnd_next        = hnd_reg;
        prev_valid_next = prev_valid_reg;
        best_valid_next = best_valid_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        prev_next       = prev_reg;
        prev_idx_next   = prev_idx_reg;
        kof_next        = kof_reg;
        out_valid_next  = out_valid_reg && !out_fire;
        out_handle_next = out_handle_reg;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        ent_we    = 1'b0;
        ent_waddr = wr_reg[IDX_W-1:0];
        ent_wdata = ent_rdata;
        ent_re    = 1'b0;
        ent_raddr = rd_reg[IDX_W-1:0];
        key_we    = 1'b0;
        key_waddr = rd_reg[IDX_W-1:0];
        key_wdata = '{key: ku_key, one_frame: kof_reg, handle: hnd_reg};
        key_re    = 1'b0;
        key_raddr = rd_reg[IDX_W-1:0];
        ku_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next = command;
                    hnd_next = handle;
                    rd_next  = '0;
                    wr_next  = '0;
                    case (command)
                        CMD_ADD_PERSIST, CMD_ADD_FRAME:
                        begin
                            out_valid_next  = 1'b1;
                            out_handle_next = '0;
                            out_entry_next  = 1'b0;
                            out_last_next   = 1'b1;
                            if (count_reg == CAP_CNT)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                out_status_next = ST_OK;
                                ent_we    = 1'b1;
                                ent_waddr = count_reg[IDX_W-1:0];
                                ent_wdata = '{handle: handle, pos_x: pos_x,
                                              pos_y: pos_y, pos_z: pos_z,
                                              one_frame: (command == CMD_ADD_FRAME)};
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        CMD_REMOVE, CMD_CLR_PERSIST, CMD_CLR_FRAME:
                        begin
                            state_next = S_COMPACT;
                        end
                        CMD_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_handle_next = '0;
                                out_entry_next  = 1'b0;
                                out_status_next = ST_EMPTY;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                emitted_next    = '0;
                                prev_valid_next = 1'b0;
                                state_next      = S_KREAD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_COMPACT:
            begin
                // Read ahead of the write index; kept entries slide down
                if (rd_reg < count_reg)
                begin
                    ent_re      = 1'b1;
                    rd_next     = rd_reg + CNT_ONE;
                    rvalid_next = 1'b1;
                end
                if (rvalid_reg && !drop)
                begin
                    ent_we  = 1'b1;
                    wr_next = wr_reg + CNT_ONE;
                end
                if (!(rd_reg < count_reg) && !rvalid_reg)
                begin
                    count_next      = wr_reg;
                    out_valid_next  = 1'b1;
                    out_handle_next = '0;
                    out_entry_next  = 1'b0;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_KREAD:
            begin
                ent_re     = 1'b1;
                state_next = S_KSTART;
            end

            S_KSTART:
            begin
                ku_start   = 1'b1;
                kof_next   = ent_rdata.one_frame;
                hnd_next   = ent_rdata.handle;
                state_next = S_KWAIT;
            end

            S_KWAIT:
            begin
                if (ku_done)
                begin
                    key_we  = 1'b1;
                    rd_next = rd_reg + CNT_ONE;
                    if (rd_reg + CNT_ONE == count_reg)
                    begin
                        rd_next         = '0;
                        best_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_KREAD;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_reg < count_reg)
                begin
                    key_re      = 1'b1;
                    rd_next     = rd_reg + CNT_ONE;
                    rvalid_next = 1'b1;
                    ridx_next   = rd_reg[IDX_W-1:0];
                end
                if (rvalid_reg && eligible && better)
                begin
                    best_next       = key_rdata;
                    best_idx_next   = ridx_reg;
                    best_valid_next = 1'b1;
                end
                if (!(rd_reg < count_reg) && !rvalid_reg)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = best_reg.handle;
                    out_entry_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_last_next   = (emitted_reg + CNT_ONE == count_reg);
                    emitted_next    = emitted_reg + CNT_ONE;
                    prev_next       = best_reg;
                    prev_idx_next   = best_idx_reg;
                    prev_valid_next = 1'b1;
                    rd_next         = '0;
                    best_valid_next = 1'b0;
                    if (emitted_reg + CNT_ONE == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            emitted_reg    <= '0;
            rvalid_reg     <= 1'b0;
            cmd_reg        <= '0;
            prev_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            view_reg       <= '{cam_x: '0, cam_y: '0, cam_z: '0,
                                fwd_x: '0, fwd_y: '0, fwd_z: FORWARD_Z_RESET};
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            emitted_reg    <= emitted_next;
            rvalid_reg     <= rvalid_next;
            cmd_reg        <= cmd_next;
            prev_valid_reg <= prev_valid_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CAMERA_X:  view_reg.cam_x <= cfg_data;
                    REG_CAMERA_Y:  view_reg.cam_y <= cfg_data;
                    REG_CAMERA_Z:  view_reg.cam_z <= cfg_data;
                    REG_FORWARD_X: view_reg.fwd_x <= cfg_data;
                    REG_FORWARD_Y: view_reg.fwd_y <= cfg_data;
                    REG_FORWARD_Z: view_reg.fwd_z <= cfg_data;
                    default:       view_reg       <= view_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg       <= ridx_next;
        hnd_reg        <= hnd_next;
        kof_reg        <= kof_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        prev_reg       <= prev_next;
        prev_idx_reg   <= prev_idx_next;
        out_handle_reg <= out_handle_next;
        out_entry_reg  <= out_entry_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_handle = out_handle_reg;
    assign is_entry   = out_entry_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;

    // Table never overfills, and sort never emits more than it holds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CAP_CNT) && ((state_reg != S_EMIT) || (emitted_reg < count_reg)))
        else $error("entry count or emitted count out of range");

    // A status result always closes its request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_entry_reg) |-> out_last_reg)
        else $error("status result without last");

    // Sorted entries carry status ok
    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_entry_reg) |-> (out_status_reg == ST_OK))
        else $error("sorted entry with nonzero status");

    // Last sorted entry returns the block to idle
    a_sort_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !out_valid_reg && (emitted_reg + CNT_ONE == count_reg))
        |=> (state_reg == S_IDLE))
        else $error("sort did not finish after final entry");

endmodule
`default_nettype wire
